@@ rtl/core/block_cache_lru_controller_defines.svh @@
// Assertion macros used by the checker file of the block cache controller.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef BLOCK_CACHE_LRU_CONTROLLER_DEFINES_SVH
`define BLOCK_CACHE_LRU_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCLRU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCLRU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bclru_pkg.sv @@
`default_nettype none

package bclru_pkg;

  typedef logic [2:0] action_t;

  localparam action_t ACT_HIT           = 3'd0;
  localparam action_t ACT_FILL          = 3'd1;
  localparam action_t ACT_WRITE_BACK    = 3'd2;
  localparam action_t ACT_WRITE_THROUGH = 3'd3;
  localparam action_t ACT_STORE         = 3'd4;
  localparam action_t ACT_FLUSH_DONE    = 3'd5;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_READ        = 2'd0;
  localparam kind_t KIND_WRITE       = 2'd1;
  localparam kind_t KIND_FLUSH       = 2'd2;
  localparam kind_t KIND_FLUSH_INVAL = 2'd3;

  // Decoded request class, as it travels from the front end to the back end.
  typedef struct packed {
    logic flush;
    logic invalidate;
    logic write;
  } req_class_t;

endpackage

`default_nettype wire

@@ rtl/core/block_cache_lru_controller.sv @@
// Tag and replacement controller of a fully associative write-back or
// write-through block cache with ENTRIES slots and LRU replacement.
// Requests enter on in_valid/in_ready with kind and block; results leave on
// out_valid/out_ready with action, slot, target_block and last, where last
// marks the final result of a request. The write_through register is
// loaded from cfg_data whenever cfg_en is high and should only change while
// no request is in flight.
// A request is written into a two-entry queue; the sequencer takes it
// from there when idle, doing the tag compare and victim choice, and then
// issues its results one after another. A read hit or a plain write gives
// one result; each write-through or write-back result comes before it.
// A flush walks every slot, one per cycle while no dirty line waits on
// a stalled output, and ends with a flush-done result; a dirty line's
// write-back goes out in its own walk cycle unless the output is stalled.
// When the receiver stalls, the pending result holds in the output register
// and the sequencer waits; requests keep filling the queue until it is full.
// Reset clears all valid, dirty and age state and the write_through bit.
`default_nettype none

module block_cache_lru_controller import bclru_pkg::*; #(
  parameter int ENTRIES    = 8,
  parameter int BLOCK_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_en,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       action,
  output logic [2:0]       slot,
  output logic [31:0]      target_block,
  output logic             last
);

  localparam int TAG_W = (BLOCK_BITS < 32) ? BLOCK_BITS : 32;

  logic             write_through;
  logic             q_valid;
  logic             q_pop;
  req_class_t       q_cls;
  logic [TAG_W-1:0] q_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_through <= 1'b0;
    end else if (cfg_en) begin
      write_through <= cfg_data;
    end
  end

  bclru_front #(
    .TAG_W (TAG_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .block    (block),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cls    (q_cls),
    .q_blk    (q_blk)
  );

  bclru_back #(
    .ENTRIES (ENTRIES),
    .TAG_W   (TAG_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .write_through (write_through),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_cls         (q_cls),
    .q_blk         (q_blk),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .slot          (slot),
    .target_block  (target_block),
    .last          (last)
  );

endmodule

`default_nettype wire

@@ rtl/core/bclru_front.sv @@
`default_nettype none

module bclru_front import bclru_pkg::*; #(
  parameter int TAG_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       kind,
  input  wire logic [31:0]      block,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output req_class_t            q_cls,
  output logic [TAG_W-1:0]      q_blk
);

  // Two-entry queue between the request port and the sequencer.
  req_class_t       ent_cls [2];
  logic [TAG_W-1:0] ent_blk [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;
  req_class_t       cls;

  always_comb begin
    cls = '0;
    unique case (kind)
      KIND_READ:        cls = '{flush: 1'b0, invalidate: 1'b0, write: 1'b0};
      KIND_WRITE:       cls = '{flush: 1'b0, invalidate: 1'b0, write: 1'b1};
      KIND_FLUSH:       cls = '{flush: 1'b1, invalidate: 1'b0, write: 1'b0};
      KIND_FLUSH_INVAL: cls = '{flush: 1'b1, invalidate: 1'b1, write: 1'b0};
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_pop;
  assign q_cls    = ent_cls[rd_ptr];
  assign q_blk    = ent_blk[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Only the low TAG_W bits of the block number take part in the cache.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_cls[wr_ptr] <= cls;
      ent_blk[wr_ptr] <= block[TAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bclru_back.sv @@
`default_nettype none

module bclru_back import bclru_pkg::*; #(
  parameter int ENTRIES = 8,
  parameter int TAG_W   = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             write_through,
  input  wire logic             q_valid,
  output logic                  q_pop,
  input  wire req_class_t       q_cls,
  input  wire logic [TAG_W-1:0] q_blk,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output action_t               action,
  output logic [2:0]            slot,
  output logic [31:0]           target_block,
  output logic                  last
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ACT   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dirty_q;
  logic [TAG_W-1:0]   tag_q  [ENTRIES];
  logic [SLOT_W-1:0]  rank_q [ENTRIES];

  // Request being worked on.
  logic [TAG_W-1:0]   cur_blk;
  logic               cur_write;
  logic               cur_inval;
  logic [SLOT_W-1:0]  cur_slot;
  logic               cur_was_valid;
  logic [SLOT_W-1:0]  cur_old_rank;
  action_t            cur_final;
  logic [TAG_W-1:0]   wb_tag;
  logic               pend_wt;
  logic               pend_wb;
  logic [SLOT_W-1:0]  walk;

  // Lookup and replacement choice.
  logic               hit;
  logic [SLOT_W-1:0]  hit_idx;
  logic               free;
  logic [SLOT_W-1:0]  free_idx;
  logic [SLOT_W-1:0]  old_idx;
  logic [SLOT_W-1:0]  sel;

  logic               out_free;
  logic               push;
  action_t            push_action;
  logic [SLOT_W-1:0]  push_slot;
  logic [TAG_W-1:0]   push_tgt;
  logic               push_last;
  logic               act_final;
  logic               walk_step;
  logic               walk_wb;
  logic               take;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    old_idx  = '0;
    // Descending scan so that the lowest matching slot wins.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == q_blk) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
    // Ascending scan so that the highest free slot wins.
    for (int i = 0; i < ENTRIES; i++) begin
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    // With every line valid the ranks are a permutation, so the oldest line
    // is the one holding the largest rank.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (rank_q[i] == TOP_SLOT) begin
        old_idx = SLOT_W'(i);
      end
    end
    sel = hit ? hit_idx : (free ? free_idx : old_idx);
  end

  assign out_free = !out_valid || out_ready;
  assign take     = (state == ST_IDLE) && q_valid;

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    push        = 1'b0;
    push_action = cur_final;
    push_slot   = cur_slot;
    push_tgt    = cur_blk;
    push_last   = 1'b0;
    act_final   = 1'b0;
    walk_step   = 1'b0;
    walk_wb     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_next = q_cls.flush ? ST_FLUSH : ST_ACT;
        end
      end
      ST_ACT: begin
        if (out_free) begin
          push = 1'b1;
          priority if (pend_wt) begin
            push_action = ACT_WRITE_THROUGH;
          end else if (pend_wb) begin
            push_action = ACT_WRITE_BACK;
            push_tgt    = wb_tag;
          end else begin
            push_action = cur_final;
            push_last   = 1'b1;
            act_final   = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        walk_wb = valid_q[walk] && dirty_q[walk];
        // Clean or invalid lines pass without waiting for the output.
        if (!walk_wb || out_free) begin
          walk_step   = 1'b1;
          push        = walk_wb;
          push_action = ACT_WRITE_BACK;
          push_slot   = walk;
          push_tgt    = tag_q[walk];
          if (walk == TOP_SLOT) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          push        = 1'b1;
          push_action = ACT_FLUSH_DONE;
          push_slot   = '0;
          push_tgt    = '0;
          push_last   = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid_q <= '0;
      dirty_q <= '0;
      pend_wt <= 1'b0;
      pend_wb <= 1'b0;
      walk    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (take) begin
        walk    <= '0;
        pend_wt <= !q_cls.flush && q_cls.write && write_through;
        pend_wb <= !q_cls.flush && !hit && valid_q[sel] && dirty_q[sel];
      end
      if (push && state == ST_ACT && push_action == ACT_WRITE_THROUGH) begin
        pend_wt <= 1'b0;
      end
      if (push && state == ST_ACT && push_action == ACT_WRITE_BACK) begin
        pend_wb <= 1'b0;
      end
      if (act_final) begin
        // Age every valid line younger than the touched one; a newly
        // allocated line ages all valid lines.
        for (int t = 0; t < ENTRIES; t++) begin
          if (SLOT_W'(t) != cur_slot && valid_q[t] &&
              (!cur_was_valid || rank_q[t] < cur_old_rank)) begin
            rank_q[t] <= rank_q[t] + SLOT_W'(1);
          end
        end
        rank_q[cur_slot] <= '0;
        if (cur_final != ACT_HIT) begin
          valid_q[cur_slot] <= 1'b1;
          dirty_q[cur_slot] <= cur_write && !write_through;
        end
      end
      if (walk_step) begin
        walk <= walk + SLOT_W'(1);
        if (walk_wb || (cur_inval && valid_q[walk])) begin
          dirty_q[walk] <= 1'b0;
        end
        if (cur_inval && valid_q[walk]) begin
          valid_q[walk] <= 1'b0;
          rank_q[walk]  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_blk       <= q_blk;
      cur_write     <= q_cls.write;
      cur_inval     <= q_cls.invalidate;
      cur_slot      <= sel;
      cur_was_valid <= valid_q[sel];
      cur_old_rank  <= rank_q[sel];
      wb_tag        <= tag_q[sel];
      cur_final     <= q_cls.write ? ACT_STORE : (hit ? ACT_HIT : ACT_FILL);
    end
    if (act_final && cur_final != ACT_HIT) begin
      tag_q[cur_slot] <= cur_blk;
    end
  end

  // Output register: the next result may be loaded while this one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      action       <= push_action;
      slot         <= 3'(push_slot);
      target_block <= 32'(push_tgt);
      last         <= push_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bclru_checker.sv @@
`default_nettype none
`include "block_cache_lru_controller_defines.svh"

module bclru_checker import bclru_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  action,
  input wire logic [2:0]  slot,
  input wire logic [31:0] target_block,
  input wire logic        last
);

  `BCLRU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(action) && $stable(slot) && $stable(target_block) && $stable(last), "result changed while stalled")

  `BCLRU_ASSERT_IMP(a_action_code, out_valid, action <= ACT_FLUSH_DONE, "undefined action code")

  `BCLRU_ASSERT_IMP(a_done_fields, out_valid && action == ACT_FLUSH_DONE, slot == 3'd0 && target_block == 32'd0 && last, "flush done item malformed")

  // Only a hit, fill, store or flush done ends a request.
  `BCLRU_ASSERT_IMP(a_last_kind, out_valid, last == (action == ACT_HIT || action == ACT_FILL || action == ACT_STORE || action == ACT_FLUSH_DONE), "last flag does not match action")

endmodule

bind block_cache_lru_controller bclru_checker u_bclru_checker (.*);

`default_nettype wire
